// ----- design/ipc_pkg.sv -----
`default_nettype none

package ipc_pkg;

   // Averaging window and tick counter wrap.
   localparam int SAMPLES_PER_AVERAGE = 100;
   localparam int TICK_WRAP = 10000;

   localparam int RAW_W = 12;
   localparam int TEMP_W = 8;
   localparam int DRY_W = 7;
   localparam int TICKS_W = 16;
   localparam int LEVEL_W = 3;
   localparam int INTENSITY_W = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam int SUM_W = 19;
   localparam int TICK_W = $clog2(TICK_WRAP);
   localparam int AVG_CNT_W = $clog2(SAMPLES_PER_AVERAGE);
   localparam int AVG_W = $clog2(((2 ** SUM_W) - 1) / SAMPLES_PER_AVERAGE + 1);
   localparam int SPAN_W = RAW_W + 1;
   localparam int DIFF_W = ((AVG_W > RAW_W) ? AVG_W : RAW_W) + 1;
   localparam int PCT_W = DIFF_W + 8;
   localparam int REFRESH_W = 4;

   localparam int LEVEL_STEPS = 6;
   localparam int LEVEL_DENOM = 7;
   localparam int PERCENT_FULL = 100;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam logic [TICKS_W-1:0] TICKS_MAX = '1;
   localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICK_WRAP - 1);
   localparam logic [AVG_CNT_W-1:0] AVG_CNT_LAST = AVG_CNT_W'(SAMPLES_PER_AVERAGE - 1);
   localparam logic [1:0] PHASE3_LAST = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_STROBE_MAX = 3'd2;
   localparam logic [INTENSITY_W-1:0] INTENSITY_IDLE = 4'h7;
   localparam logic [INTENSITY_W-1:0] INTENSITY_MAX = 4'hF;

   // Calibration defaults.
   localparam logic [RAW_W-1:0] RST_SOIL_AIR = 12'd3482;
   localparam logic [RAW_W-1:0] RST_SOIL_WET = 12'd1597;
   localparam logic [RAW_W-1:0] RST_WATER_EMPTY = 12'd410;
   localparam logic [RAW_W-1:0] RST_WATER_FULL = 12'd2662;
   localparam logic [DRY_W-1:0] RST_SOIL_DRY = 7'd25;
   localparam logic signed [TEMP_W-1:0] RST_FAN_ON = 8'sd30;
   localparam logic [TICKS_W-1:0] RST_PUMP_RUN = 16'd125;
   localparam logic [TICKS_W-1:0] RST_PUMP_LOCKOUT = 16'd1409;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOIL_AIR     = 3'd0,
      CSR_SOIL_WET     = 3'd1,
      CSR_WATER_EMPTY  = 3'd2,
      CSR_WATER_FULL   = 3'd3,
      CSR_SOIL_DRY     = 3'd4,
      CSR_FAN_ON       = 3'd5,
      CSR_PUMP_RUN     = 3'd6,
      CSR_PUMP_LOCKOUT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [RAW_W-1:0] soil_air;
      logic [RAW_W-1:0] soil_wet;
      logic [RAW_W-1:0] water_empty;
      logic [RAW_W-1:0] water_full;
      logic [DRY_W-1:0] soil_dry;
   } calib_type;

   typedef struct packed {
      logic water_ok;
      logic soil_dry;
      logic [LEVEL_W-1:0] level;
   } eval_type;

endpackage

`default_nettype wire

// ----- design/irrigation_pump_controller.sv -----
// Irrigation pump controller: one request per control tick.
// A request carries temperature, soil and water samples and the mode button.
// Each request yields exactly one response with fan, pump and display controls.
// A request is registered first in the request stage and then in the response register.
// Throughput: one request per cycle; the input register and the response
// register are separated, so a new request is taken while a response waits.
// When rsp_ready is low the response holds, the request stage fills, and
// req_ready drops until the response is taken.
// Every SAMPLES_PER_AVERAGE ticks the summed samples are averaged (a constant
// reciprocal multiply), compared against the calibration points and cleared.
// Configuration registers are written through the csr_ channel at any cycle
// (csr_ready is always high) but should only change while no request is in
// flight. Reset is synchronous and active high: it empties both stages,
// restores all calibration defaults and sets the pump ready, the strobe off
// and the brightness to its idle value.
`default_nettype none

module irrigation_pump_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [ipc_pkg::TEMP_W-1:0]   req_temperature,
   input  wire logic [ipc_pkg::RAW_W-1:0]           req_soil_sample,
   input  wire logic [ipc_pkg::RAW_W-1:0]           req_water_sample,
   input  wire logic                                req_mode_button,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_fan_drive,
   output logic                                     rsp_pump_drive,
   output logic                                     rsp_pump_ready,
   output logic                                     rsp_level_update,
   output logic [ipc_pkg::LEVEL_W-1:0]              rsp_water_level,
   output logic                                     rsp_display_blank,
   output logic [ipc_pkg::INTENSITY_W-1:0]          rsp_brightness,
   output logic                                     rsp_brightness_write,
   output logic                                     rsp_lcd_refresh,
   output logic                                     rsp_display_mode,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ipc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [ipc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ipc_pkg::*;

   // Configuration registers.
   logic [RAW_W-1:0] cfg_soil_air_ff;
   logic [RAW_W-1:0] cfg_soil_wet_ff;
   logic [RAW_W-1:0] cfg_water_empty_ff;
   logic [RAW_W-1:0] cfg_water_full_ff;
   logic [DRY_W-1:0] cfg_soil_dry_ff;
   logic signed [TEMP_W-1:0] cfg_fan_on_ff;
   logic [TICKS_W-1:0] cfg_pump_run_ff;
   logic [TICKS_W-1:0] cfg_pump_lockout_ff;

   // Request stage.
   logic s1_valid_ff;
   logic signed [TEMP_W-1:0] s1_temp_ff;
   logic [RAW_W-1:0] s1_soil_ff;
   logic [RAW_W-1:0] s1_water_ff;
   logic s1_button_ff;

   // Controller state.
   logic [TICK_W-1:0] tick_count_ff, tick_count_in;
   logic [1:0] phase3_ff, phase3_in;
   logic [AVG_CNT_W-1:0] avg_cnt_ff, avg_cnt_in;
   logic [SUM_W-1:0] soil_sum_ff, soil_sum_in;
   logic [SUM_W-1:0] water_sum_ff, water_sum_in;
   logic pump_active_ff, pump_active_in;
   logic pump_allowed_ff, pump_allowed_in;
   logic [TICKS_W-1:0] pump_ticks_ff, pump_ticks_in;
   logic strobe_active_ff, strobe_active_in;
   logic strobe_rising_ff, strobe_rising_in;
   logic [INTENSITY_W-1:0] intensity_ff, intensity_in;
   logic page_select_ff, page_select_in;

   // Response register.
   logic rsp_valid_ff;
   logic rsp_fan_drive_ff, rsp_fan_drive_in;
   logic rsp_level_update_ff, rsp_level_update_in;
   logic [LEVEL_W-1:0] rsp_water_level_ff, rsp_water_level_in;
   logic rsp_display_blank_ff, rsp_display_blank_in;
   logic rsp_brightness_write_ff, rsp_brightness_write_in;
   logic rsp_lcd_refresh_ff, rsp_lcd_refresh_in;
   logic rsp_pump_drive_ff;
   logic rsp_pump_ready_ff;
   logic [INTENSITY_W-1:0] rsp_brightness_ff;
   logic rsp_display_mode_ff;

   logic advance;
   logic tick_wrap;
   logic avg_now;
   logic start;
   logic pump_on;
   logic [SUM_W:0] soil_acc;
   logic [SUM_W:0] water_acc;
   logic [SUM_W-1:0] soil_sat;
   logic [SUM_W-1:0] water_sat;
   logic [TICKS_W-1:0] ticks_base;
   calib_type calib;
   eval_type eval_res;

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign calib.soil_air = cfg_soil_air_ff;
   assign calib.soil_wet = cfg_soil_wet_ff;
   assign calib.water_empty = cfg_water_empty_ff;
   assign calib.water_full = cfg_water_full_ff;
   assign calib.soil_dry = cfg_soil_dry_ff;

   ipc_eval u_eval (
      .soil_sum  (soil_sat),
      .water_sum (water_sat),
      .calib     (calib),
      .result    (eval_res)
   );

   always_comb begin
      tick_wrap = tick_count_ff == TICK_LAST;
      tick_count_in = tick_wrap ? '0 : tick_count_ff + TICK_W'(1);
      phase3_in = (tick_wrap || phase3_ff == PHASE3_LAST) ? '0 : phase3_ff + 2'd1;
      avg_cnt_in = (tick_wrap || avg_cnt_ff == AVG_CNT_LAST) ? '0
                                                             : avg_cnt_ff + AVG_CNT_W'(1);
      avg_now = avg_cnt_in == '0;

      // Triangle strobe steps on every third tick while the pump is off.
      intensity_in = intensity_ff;
      strobe_rising_in = strobe_rising_ff;
      if (strobe_active_ff && !pump_active_ff && phase3_in == '0) begin
         intensity_in = strobe_rising_ff ? intensity_ff + INTENSITY_W'(1)
                                         : intensity_ff - INTENSITY_W'(1);
         if (intensity_in == INTENSITY_MAX || intensity_in == '0) begin
            strobe_rising_in = !strobe_rising_ff;
         end
      end
      if (!strobe_active_ff && !pump_active_ff) begin
         intensity_in = INTENSITY_IDLE;
      end

      soil_acc = {1'b0, soil_sum_ff} + (SUM_W + 1)'(s1_soil_ff);
      water_acc = {1'b0, water_sum_ff} + (SUM_W + 1)'(s1_water_ff);
      soil_sat = soil_acc[SUM_W] ? SUM_MAX : soil_acc[SUM_W-1:0];
      water_sat = water_acc[SUM_W] ? SUM_MAX : water_acc[SUM_W-1:0];
      soil_sum_in = avg_now ? '0 : soil_sat;
      water_sum_in = avg_now ? '0 : water_sat;

      start = avg_now && eval_res.water_ok && eval_res.soil_dry && pump_allowed_ff;
      pump_on = pump_active_ff || start;

      rsp_fan_drive_in = (s1_temp_ff > cfg_fan_on_ff) && !start;
      rsp_display_blank_in = start;
      rsp_level_update_in = avg_now && !pump_on;
      rsp_water_level_in = rsp_level_update_in ? eval_res.level : '0;
      strobe_active_in = rsp_level_update_in ? (eval_res.level <= LEVEL_STROBE_MAX)
                                             : strobe_active_ff;
      rsp_lcd_refresh_in = (tick_count_in[REFRESH_W-1:0] == '0) && !pump_on;
      rsp_brightness_write_in = !pump_on;

      ticks_base = start ? '0 : pump_ticks_ff;
      pump_ticks_in = (ticks_base == TICKS_MAX) ? ticks_base : ticks_base + TICKS_W'(1);
      pump_active_in = pump_on && !(pump_ticks_in >= cfg_pump_run_ff);
      pump_allowed_in = (pump_allowed_ff && !start)
                        || (!pump_active_in && pump_ticks_in >= cfg_pump_lockout_ff);

      page_select_in = page_select_ff ^ s1_button_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tick_count_ff <= '0;
         phase3_ff <= '0;
         avg_cnt_ff <= '0;
         soil_sum_ff <= '0;
         water_sum_ff <= '0;
         pump_active_ff <= 1'b0;
         pump_allowed_ff <= 1'b1;
         pump_ticks_ff <= '0;
         strobe_active_ff <= 1'b0;
         strobe_rising_ff <= 1'b1;
         intensity_ff <= INTENSITY_IDLE;
         page_select_ff <= 1'b0;
         cfg_soil_air_ff <= RST_SOIL_AIR;
         cfg_soil_wet_ff <= RST_SOIL_WET;
         cfg_water_empty_ff <= RST_WATER_EMPTY;
         cfg_water_full_ff <= RST_WATER_FULL;
         cfg_soil_dry_ff <= RST_SOIL_DRY;
         cfg_fan_on_ff <= RST_FAN_ON;
         cfg_pump_run_ff <= RST_PUMP_RUN;
         cfg_pump_lockout_ff <= RST_PUMP_LOCKOUT;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            tick_count_ff <= tick_count_in;
            phase3_ff <= phase3_in;
            avg_cnt_ff <= avg_cnt_in;
            soil_sum_ff <= soil_sum_in;
            water_sum_ff <= water_sum_in;
            pump_active_ff <= pump_active_in;
            pump_allowed_ff <= pump_allowed_in;
            pump_ticks_ff <= pump_ticks_in;
            strobe_active_ff <= strobe_active_in;
            strobe_rising_ff <= strobe_rising_in;
            intensity_ff <= intensity_in;
            page_select_ff <= page_select_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SOIL_AIR: begin
                  cfg_soil_air_ff <= csr_data[RAW_W-1:0];
               end
               CSR_SOIL_WET: begin
                  cfg_soil_wet_ff <= csr_data[RAW_W-1:0];
               end
               CSR_WATER_EMPTY: begin
                  cfg_water_empty_ff <= csr_data[RAW_W-1:0];
               end
               CSR_WATER_FULL: begin
                  cfg_water_full_ff <= csr_data[RAW_W-1:0];
               end
               CSR_SOIL_DRY: begin
                  cfg_soil_dry_ff <= csr_data[DRY_W-1:0];
               end
               CSR_FAN_ON: begin
                  cfg_fan_on_ff <= $signed(csr_data[TEMP_W-1:0]);
               end
               CSR_PUMP_RUN: begin
                  cfg_pump_run_ff <= csr_data[TICKS_W-1:0];
               end
               CSR_PUMP_LOCKOUT: begin
                  cfg_pump_lockout_ff <= csr_data[TICKS_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_temp_ff <= req_temperature;
         s1_soil_ff <= req_soil_sample;
         s1_water_ff <= req_water_sample;
         s1_button_ff <= req_mode_button;
      end
      if (advance) begin
         rsp_fan_drive_ff <= rsp_fan_drive_in;
         rsp_pump_drive_ff <= pump_active_in;
         rsp_pump_ready_ff <= pump_allowed_in;
         rsp_level_update_ff <= rsp_level_update_in;
         rsp_water_level_ff <= rsp_water_level_in;
         rsp_display_blank_ff <= rsp_display_blank_in;
         rsp_brightness_ff <= intensity_in;
         rsp_brightness_write_ff <= rsp_brightness_write_in;
         rsp_lcd_refresh_ff <= rsp_lcd_refresh_in;
         rsp_display_mode_ff <= page_select_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_fan_drive = rsp_fan_drive_ff;
   assign rsp_pump_drive = rsp_pump_drive_ff;
   assign rsp_pump_ready = rsp_pump_ready_ff;
   assign rsp_level_update = rsp_level_update_ff;
   assign rsp_water_level = rsp_water_level_ff;
   assign rsp_display_blank = rsp_display_blank_ff;
   assign rsp_brightness = rsp_brightness_ff;
   assign rsp_brightness_write = rsp_brightness_write_ff;
   assign rsp_lcd_refresh = rsp_lcd_refresh_ff;
   assign rsp_display_mode = rsp_display_mode_ff;

`ifndef SYNTHESIS
   // A running pump always holds the lockout.
   assert property (@(posedge clock) disable iff (reset)
      pump_active_ff |-> !pump_allowed_ff)
      else $error("pump running while a new start is allowed");

   // A pump start tick never turns the fan on or shows a level.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_display_blank_ff |-> !rsp_fan_drive_ff && !rsp_level_update_ff)
      else $error("pump start response carries fan or level update");

   // The tick and averaging counters stay in range.
   assert property (@(posedge clock) disable iff (reset)
      tick_count_ff <= TICK_LAST && avg_cnt_ff <= AVG_CNT_LAST && phase3_ff <= PHASE3_LAST)
      else $error("tick counters out of range");

   // The request stage never overwrites a response that is still stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !advance)
      else $error("response overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ----- design/ipc_eval.sv -----
`default_nettype none

module ipc_eval (
   input  wire logic [ipc_pkg::SUM_W-1:0] soil_sum,
   input  wire logic [ipc_pkg::SUM_W-1:0] water_sum,
   input  wire ipc_pkg::calib_type        calib,
   output ipc_pkg::eval_type              result
);
   import ipc_pkg::*;

   localparam int RECIP_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
   localparam int RECIP_W = SUM_W + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2 ** RECIP_SHIFT + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
   localparam logic signed [PCT_W-1:0] HUNDRED = PCT_W'(PERCENT_FULL);
   localparam logic signed [PCT_W-1:0] NEG_HUNDRED = PCT_W'(-PERCENT_FULL);
   localparam logic signed [PCT_W-1:0] SEVEN = PCT_W'(LEVEL_DENOM);

   // The rounded-up reciprocal carries enough fraction bits that the product
   // gives the truncated quotient exactly for every sum.
   function automatic logic [AVG_W-1:0] div_samples(input logic [SUM_W-1:0] sum);
      logic [SUM_W+RECIP_W-1:0] prod;
      prod = {{RECIP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP};
      return prod[RECIP_SHIFT +: AVG_W];
   endfunction

   // Percent strictly above the threshold. With a zero span only the sign of
   // the numerator decides, and a zero numerator compares false.
   function automatic logic pct_gt(input logic signed [PCT_W-1:0] lhs,
                                   input logic signed [PCT_W-1:0] rhs,
                                   input logic signed [SPAN_W-1:0] span,
                                   input logic signed [DIFF_W-1:0] num);
      logic res;
      if (span == '0) begin
         res = num > 0;
      end else if (span > 0) begin
         res = lhs > rhs;
      end else begin
         res = lhs < rhs;
      end
      return res;
   endfunction

   function automatic logic pct_le(input logic signed [PCT_W-1:0] lhs,
                                   input logic signed [PCT_W-1:0] rhs,
                                   input logic signed [SPAN_W-1:0] span,
                                   input logic signed [DIFF_W-1:0] num);
      logic res;
      if (span == '0) begin
         res = num < 0;
      end else if (span > 0) begin
         res = lhs <= rhs;
      end else begin
         res = lhs >= rhs;
      end
      return res;
   endfunction

   logic [AVG_W-1:0] soil_avg;
   logic [AVG_W-1:0] water_avg;
   logic signed [SPAN_W-1:0] soil_span;
   logic signed [SPAN_W-1:0] water_span;
   logic signed [DIFF_W-1:0] soil_num;
   logic signed [DIFF_W-1:0] water_num;
   logic signed [PCT_W-1:0] soil_num_x;
   logic signed [PCT_W-1:0] water_num_x;
   logic signed [PCT_W-1:0] soil_span_x;
   logic signed [PCT_W-1:0] water_span_x;
   logic signed [PCT_W-1:0] soil_thr;
   logic signed [PCT_W-1:0] water_scaled;
   logic signed [PCT_W-1:0] step_thr;
   logic [LEVEL_W-1:0] level;

   always_comb begin
      soil_avg = div_samples(soil_sum);
      water_avg = div_samples(water_sum);
      soil_span = $signed(SPAN_W'(calib.soil_wet)) - $signed(SPAN_W'(calib.soil_air));
      water_span = $signed(SPAN_W'(calib.water_full)) - $signed(SPAN_W'(calib.water_empty));
      soil_num = $signed(DIFF_W'(soil_avg)) - $signed(DIFF_W'(calib.soil_air));
      water_num = $signed(DIFF_W'(water_avg)) - $signed(DIFF_W'(calib.water_empty));
      soil_num_x = PCT_W'(soil_num);
      water_num_x = PCT_W'(water_num);
      soil_span_x = PCT_W'(soil_span);
      water_span_x = PCT_W'(water_span);
      soil_thr = soil_span_x * $signed(PCT_W'(calib.soil_dry));
      water_scaled = water_num_x * SEVEN;

      level = '0;
      for (int k = 1; k <= LEVEL_STEPS; k++) begin
         step_thr = water_span_x * $signed(PCT_W'(k));
         if (pct_gt(water_scaled, step_thr, water_span, water_num)) begin
            level = LEVEL_W'(k);
         end
      end

      result.water_ok = pct_gt(water_num_x, water_span_x * NEG_HUNDRED, water_span,
                               water_num);
      result.soil_dry = pct_le(soil_num_x * HUNDRED, soil_thr, soil_span, soil_num);
      result.level = level;
   end

endmodule

`default_nettype wire
